[design/vmbd_pkg.sv]
package vmbd_pkg;

  localparam int LEVEL_W = 4;
  localparam int COORD_W = 7;
  localparam int MEAN_W  = 16;
  localparam int CFG_W   = 4;

  localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

endpackage

[design/vmbd_front.sv]
module vmbd_front #(
  parameter int MAX_LOG2    = 8,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [vmbd_pkg::CFG_W-1:0]    cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [SAMPLE_BITS-1:0]        sample_i,
  output logic                          push_valid_o,
  input  logic                          push_ready_i,
  output logic [SAMPLE_BITS-1:0]        push_sample_o,
  output logic [MAX_LOG2-1:0]           push_x_o,
  output logic [MAX_LOG2-1:0]           push_y_o,
  output logic [MAX_LOG2-1:0]           push_z_o,
  output logic [vmbd_pkg::LEVEL_W-1:0]  push_lvl_o,
  output logic [MAX_LOG2-1:0]           push_first_o,
  output logic [MAX_LOG2-1:0]           push_done_o
);
  import vmbd_pkg::*;

  logic [CFG_W-1:0]    log2_q;
  logic [LEVEL_W-1:0]  lvl;
  logic [MAX_LOG2-1:0] edge_m1;
  logic [MAX_LOG2-1:0] pos_x_q, pos_y_q, pos_z_q;
  logic [MAX_LOG2-1:0] pos_x_d, pos_y_d, pos_z_d;
  logic                accept;

  always_comb begin
    priority if (log2_q == '0) begin
      lvl = LEVEL_W'(1);
    end else if (log2_q > CFG_W'(MAX_LOG2)) begin
      lvl = LEVEL_W'(MAX_LOG2);
    end else begin
      lvl = LEVEL_W'(log2_q);
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_LOG2; i++) begin
      edge_m1[i] = (LEVEL_W'(i) < lvl);
    end
  end

  assign cfg_ready_o  = 1'b1;
  assign in_stall_o   = !push_ready_i;
  assign push_valid_o = in_valid_i;
  assign accept       = in_valid_i && push_ready_i;

  assign push_sample_o = sample_i;
  assign push_x_o      = pos_x_q;
  assign push_y_o      = pos_y_q;
  assign push_z_o      = pos_z_q;
  assign push_lvl_o    = lvl;

  for (genvar k = 1; k <= MAX_LOG2; k++) begin : g_lvl
    logic act;
    assign act = (LEVEL_W'(k) <= lvl);
    assign push_first_o[k-1] = act && (pos_x_q[k-1:0] == '0) && (pos_y_q[k-1:0] == '0)
                               && (pos_z_q[k-1:0] == '0);
    assign push_done_o[k-1]  = act && (&pos_x_q[k-1:0]) && (&pos_y_q[k-1:0])
                               && (&pos_z_q[k-1:0]);
  end

  always_comb begin
    pos_x_d = pos_x_q + MAX_LOG2'(1);
    pos_y_d = pos_y_q;
    pos_z_d = pos_z_q;
    if (pos_x_q == edge_m1) begin
      pos_x_d = '0;
      pos_y_d = pos_y_q + MAX_LOG2'(1);
      if (pos_y_q == edge_m1) begin
        pos_y_d = '0;
        pos_z_d = pos_z_q + MAX_LOG2'(1);
        if (pos_z_q == edge_m1) begin
          pos_z_d = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      log2_q  <= CFG_RESET;
      pos_x_q <= '0;
      pos_y_q <= '0;
      pos_z_q <= '0;
    end else if (cfg_valid_i) begin
      log2_q  <= cfg_data_i;
      pos_x_q <= '0;
      pos_y_q <= '0;
      pos_z_q <= '0;
    end else if (accept) begin
      pos_x_q <= pos_x_d;
      pos_y_q <= pos_y_d;
      pos_z_q <= pos_z_d;
    end
  end

endmodule

[design/vmbd_fifo.sv]
module vmbd_fifo #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  logic [DATA_W-1:0] push_data_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output logic [DATA_W-1:0] pop_data_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [DATA_W-1:0] slot_q [DEPTH];
  logic [AW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [AW:0]       count_q;
  logic              push, pop;

  assign push_ready_o = (count_q != (AW+1)'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + (AW+1)'(1);
      end else if (pop && !push) begin
        count_q <= count_q - (AW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[design/vmbd_accum.sv]
module vmbd_accum #(
  parameter int MAX_LOG2    = 8,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  input  logic                                            q_valid_i,
  output logic                                            q_ready_o,
  input  logic [SAMPLE_BITS-1:0]                          q_sample_i,
  input  logic [MAX_LOG2-1:0]                             q_x_i,
  input  logic [MAX_LOG2-1:0]                             q_y_i,
  input  logic [MAX_LOG2-1:0]                             q_z_i,
  input  logic [vmbd_pkg::LEVEL_W-1:0]                    q_lvl_i,
  input  logic [MAX_LOG2-1:0]                             q_first_i,
  input  logic [MAX_LOG2-1:0]                             q_done_i,
  output logic                                            bnd_valid_o,
  input  logic                                            bnd_ready_i,
  output logic [MAX_LOG2-1:0]                             bnd_done_o,
  output logic [MAX_LOG2-1:0]                             bnd_x_o,
  output logic [MAX_LOG2-1:0]                             bnd_y_o,
  output logic [MAX_LOG2-1:0]                             bnd_z_o,
  output logic [MAX_LOG2*(SAMPLE_BITS+3*MAX_LOG2)-1:0]    bnd_sums_o
);
  import vmbd_pkg::*;

  localparam int SUM_W = SAMPLE_BITS + 3 * MAX_LOG2;

  logic                   a_valid_q;
  logic [SAMPLE_BITS-1:0] a_sample_q;
  logic [MAX_LOG2-1:0]    a_x_q, a_y_q, a_z_q;
  logic [LEVEL_W-1:0]     a_lvl_q;
  logic [MAX_LOG2-1:0]    a_first_q, a_done_q;
  logic                   a_fire, pop;

  assign a_fire    = a_valid_q && ((a_done_q == '0) || bnd_ready_i);
  assign q_ready_o = !a_valid_q || a_fire;
  assign pop       = q_valid_i && q_ready_o;

  assign bnd_valid_o = a_valid_q && (a_done_q != '0);
  assign bnd_done_o  = a_done_q;
  assign bnd_x_o     = a_x_q;
  assign bnd_y_o     = a_y_q;
  assign bnd_z_o     = a_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (q_ready_o) begin
      a_valid_q <= q_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      a_sample_q <= q_sample_i;
      a_x_q      <= q_x_i;
      a_y_q      <= q_y_i;
      a_z_q      <= q_z_i;
      a_lvl_q    <= q_lvl_i;
      a_first_q  <= q_first_i;
      a_done_q   <= q_done_i;
    end
  end

  // Each level has its own sum memory; the last write is kept beside it so that
  // a read that raced that write still sees the current sum.
  for (genvar k = 1; k <= MAX_LOG2; k++) begin : g_lvl
    localparam int SW    = SAMPLE_BITS + 3 * k;
    localparam int AW    = (k < MAX_LOG2) ? 2 * (MAX_LOG2 - k) : 1;
    localparam int DEPTH = 1 << AW;

    logic [SW-1:0] acc_mem_q [DEPTH];
    logic [SW-1:0] rd_q;
    logic [AW-1:0] rd_addr, wr_addr;
    logic          lw_valid_q;
    logic [AW-1:0] lw_addr_q;
    logic [SW-1:0] lw_data_q;
    logic [SW-1:0] base, sum;
    logic          wr_en;

    if (k < MAX_LOG2) begin : g_addr
      assign rd_addr = {q_y_i[MAX_LOG2-1:k], q_x_i[MAX_LOG2-1:k]};
      assign wr_addr = {a_y_q[MAX_LOG2-1:k], a_x_q[MAX_LOG2-1:k]};
    end else begin : g_addr
      assign rd_addr = '0;
      assign wr_addr = '0;
    end

    assign wr_en = a_fire && (LEVEL_W'(k) <= a_lvl_q);
    assign base  = (lw_valid_q && (lw_addr_q == wr_addr)) ? lw_data_q : rd_q;
    assign sum   = a_first_q[k-1] ? SW'(a_sample_q) : base + SW'(a_sample_q);

    assign bnd_sums_o[(k-1)*SUM_W +: SUM_W] = SUM_W'(sum);

    always_ff @(posedge clk_i) begin
      if (pop) begin
        rd_q <= acc_mem_q[rd_addr];
      end
      if (wr_en) begin
        acc_mem_q[wr_addr] <= sum;
        lw_addr_q          <= wr_addr;
        lw_data_q          <= sum;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        lw_valid_q <= 1'b0;
      end else if (wr_en) begin
        lw_valid_q <= 1'b1;
      end
    end
  end

endmodule

[design/vmbd_emit.sv]
module vmbd_emit #(
  parameter int MAX_LOG2    = 8,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          bnd_valid_i,
  output logic                                          bnd_ready_o,
  input  logic [MAX_LOG2-1:0]                           bnd_done_i,
  input  logic [MAX_LOG2-1:0]                           bnd_x_i,
  input  logic [MAX_LOG2-1:0]                           bnd_y_i,
  input  logic [MAX_LOG2-1:0]                           bnd_z_i,
  input  logic [MAX_LOG2*(SAMPLE_BITS+3*MAX_LOG2)-1:0]  bnd_sums_i,
  output logic                                          out_valid_o,
  input  logic                                          out_stall_i,
  output logic [vmbd_pkg::LEVEL_W-1:0]                  level_o,
  output logic [vmbd_pkg::COORD_W-1:0]                  vox_x_o,
  output logic [vmbd_pkg::COORD_W-1:0]                  vox_y_o,
  output logic [vmbd_pkg::COORD_W-1:0]                  vox_z_o,
  output logic [vmbd_pkg::MEAN_W-1:0]                   mean_o,
  output logic                                          last_o
);
  import vmbd_pkg::*;

  localparam int SUM_W = SAMPLE_BITS + 3 * MAX_LOG2;

  logic                        b_valid_q;
  logic [MAX_LOG2-1:0]         b_rem_q;
  logic [MAX_LOG2*SUM_W-1:0]   b_sums_q;
  logic [MAX_LOG2-1:0]         b_x_q, b_y_q, b_z_q;
  logic [MAX_LOG2-1:0]         pick;
  logic                        pick_last, out_load, b_step, b_finish;

  logic [MEAN_W-1:0]  mean_lv [MAX_LOG2];
  logic [COORD_W-1:0] vx_lv [MAX_LOG2];
  logic [COORD_W-1:0] vy_lv [MAX_LOG2];
  logic [COORD_W-1:0] vz_lv [MAX_LOG2];

  logic [LEVEL_W-1:0] sel_lvl;
  logic [COORD_W-1:0] sel_x, sel_y, sel_z;
  logic [MEAN_W-1:0]  sel_mean;

  logic               out_valid_q;
  logic [LEVEL_W-1:0] level_q;
  logic [COORD_W-1:0] vox_x_q, vox_y_q, vox_z_q;
  logic [MEAN_W-1:0]  mean_q;
  logic               last_q;

  // Results leave in ascending level order: the lowest pending level goes first.
  assign pick      = b_rem_q & (~b_rem_q + MAX_LOG2'(1));
  assign pick_last = ((b_rem_q & ~pick) == '0);
  assign out_load  = !out_valid_q || !out_stall_i;
  assign b_step    = b_valid_q && out_load;
  assign b_finish  = b_step && pick_last;

  assign bnd_ready_o = !b_valid_q || b_finish;

  for (genvar k = 1; k <= MAX_LOG2; k++) begin : g_lvl
    localparam int SW = SAMPLE_BITS + 3 * k;
    logic [SW-1:0] s;
    logic [SW:0]   rnd;
    assign s   = b_sums_q[(k-1)*SUM_W +: SW];
    assign rnd = {1'b0, s} + ((SW+1)'(1) << (3 * k - 1));
    assign mean_lv[k-1] = MEAN_W'(rnd[SW:3*k]);
    assign vx_lv[k-1]   = COORD_W'(b_x_q >> k);
    assign vy_lv[k-1]   = COORD_W'(b_y_q >> k);
    assign vz_lv[k-1]   = COORD_W'(b_z_q >> k);
  end

  always_comb begin
    sel_lvl  = '0;
    sel_x    = '0;
    sel_y    = '0;
    sel_z    = '0;
    sel_mean = '0;
    for (int i = 0; i < MAX_LOG2; i++) begin
      if (pick[i]) begin
        sel_lvl  = LEVEL_W'(i + 1);
        sel_x    = vx_lv[i];
        sel_y    = vy_lv[i];
        sel_z    = vz_lv[i];
        sel_mean = mean_lv[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= b_valid_q;
      end
      if (bnd_valid_i && bnd_ready_o) begin
        b_valid_q <= 1'b1;
      end else if (b_finish) begin
        b_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (bnd_valid_i && bnd_ready_o) begin
      b_rem_q  <= bnd_done_i;
      b_sums_q <= bnd_sums_i;
      b_x_q    <= bnd_x_i;
      b_y_q    <= bnd_y_i;
      b_z_q    <= bnd_z_i;
    end else if (b_step) begin
      b_rem_q <= b_rem_q & ~pick;
    end
    if (b_step) begin
      level_q <= sel_lvl;
      vox_x_q <= sel_x;
      vox_y_q <= sel_y;
      vox_z_q <= sel_z;
      mean_q  <= sel_mean;
      last_q  <= pick_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign level_o     = level_q;
  assign vox_x_o     = vox_x_q;
  assign vox_y_o     = vox_y_q;
  assign vox_z_o     = vox_z_q;
  assign mean_o      = mean_q;
  assign last_o      = last_q;

`ifndef ASSERT_OFF
  a_rem_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_valid_q |-> (b_rem_q != '0))
    else $error("Pending result group holds no level.");

  a_pick_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_valid_q |-> $onehot(pick))
    else $error("Level pick is not one-hot.");

  a_more_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !last_o) |-> b_valid_q)
    else $error("A beat without last is not followed by more results.");
`endif

endmodule

[design/volume_mipmap_box_downsample_top.sv]
// Mipmap pyramid builder for a cubic volume streamed in raster order (x fastest, then y,
// then z). Every completed 2x2x2 cube at each coarser level produces one result beat with
// its level, voxel coordinates and mean rounded half up. The input takes one sample per
// cycle while in_stall_o is low; in_stall_o is raised when the descriptor queue is full.
// Results leave the output port one beat at a time, and the last beat of a sample's
// results carries last_o. The input rate is set by the single output register and by
// one read and one write per cycle on each level's sum memory. The sum memories are not
// cleared after reset: the first sample of each cube overwrites its entry. Writing
// volume_log2 restarts the volume at the origin.
module volume_mipmap_box_downsample_top #(
  parameter int MAX_LOG2    = 8,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [vmbd_pkg::CFG_W-1:0]    cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [SAMPLE_BITS-1:0]        sample_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [vmbd_pkg::LEVEL_W-1:0]  level_o,
  output logic [vmbd_pkg::COORD_W-1:0]  vox_x_o,
  output logic [vmbd_pkg::COORD_W-1:0]  vox_y_o,
  output logic [vmbd_pkg::COORD_W-1:0]  vox_z_o,
  output logic [vmbd_pkg::MEAN_W-1:0]   mean_o,
  output logic                          last_o
);
  import vmbd_pkg::*;

  localparam int QUEUE_DEPTH = 2;
  localparam int SUM_W       = SAMPLE_BITS + 3 * MAX_LOG2;
  localparam int DESC_W      = SAMPLE_BITS + 5 * MAX_LOG2 + LEVEL_W;

  logic                   push_valid, push_ready;
  logic [SAMPLE_BITS-1:0] push_sample;
  logic [MAX_LOG2-1:0]    push_x, push_y, push_z, push_first, push_done;
  logic [LEVEL_W-1:0]     push_lvl;
  logic [DESC_W-1:0]      push_desc, pop_desc;

  logic                   q_valid, q_ready;
  logic [SAMPLE_BITS-1:0] q_sample;
  logic [MAX_LOG2-1:0]    q_x, q_y, q_z, q_first, q_done;
  logic [LEVEL_W-1:0]     q_lvl;

  logic                   bnd_valid, bnd_ready;
  logic [MAX_LOG2-1:0]    bnd_done, bnd_x, bnd_y, bnd_z;
  logic [MAX_LOG2*SUM_W-1:0] bnd_sums;

  vmbd_front #(
    .MAX_LOG2    (MAX_LOG2),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .sample_i      (sample_i),
    .push_valid_o  (push_valid),
    .push_ready_i  (push_ready),
    .push_sample_o (push_sample),
    .push_x_o      (push_x),
    .push_y_o      (push_y),
    .push_z_o      (push_z),
    .push_lvl_o    (push_lvl),
    .push_first_o  (push_first),
    .push_done_o   (push_done)
  );

  assign push_desc = {push_sample, push_x, push_y, push_z, push_lvl, push_first, push_done};
  assign {q_sample, q_x, q_y, q_z, q_lvl, q_first, q_done} = pop_desc;

  vmbd_fifo #(
    .DATA_W (DESC_W),
    .DEPTH  (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_desc),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (pop_desc)
  );

  vmbd_accum #(
    .MAX_LOG2    (MAX_LOG2),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_ready_o   (q_ready),
    .q_sample_i  (q_sample),
    .q_x_i       (q_x),
    .q_y_i       (q_y),
    .q_z_i       (q_z),
    .q_lvl_i     (q_lvl),
    .q_first_i   (q_first),
    .q_done_i    (q_done),
    .bnd_valid_o (bnd_valid),
    .bnd_ready_i (bnd_ready),
    .bnd_done_o  (bnd_done),
    .bnd_x_o     (bnd_x),
    .bnd_y_o     (bnd_y),
    .bnd_z_o     (bnd_z),
    .bnd_sums_o  (bnd_sums)
  );

  vmbd_emit #(
    .MAX_LOG2    (MAX_LOG2),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .bnd_valid_i (bnd_valid),
    .bnd_ready_o (bnd_ready),
    .bnd_done_i  (bnd_done),
    .bnd_x_i     (bnd_x),
    .bnd_y_i     (bnd_y),
    .bnd_z_i     (bnd_z),
    .bnd_sums_i  (bnd_sums),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .level_o     (level_o),
    .vox_x_o     (vox_x_o),
    .vox_y_o     (vox_y_o),
    .vox_z_o     (vox_z_o),
    .mean_o      (mean_o),
    .last_o      (last_o)
  );

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

  import vmbd_pkg::*;

  localparam int SAMPLE_W     = 16;
  localparam int DRAIN_CYCLES = 16;
  localparam int CYCLE_LIMIT  = 500000;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [COORD_W-1:0] vox_x;
    logic [COORD_W-1:0] vox_y;
    logic [COORD_W-1:0] vox_z;
    logic [MEAN_W-1:0]  mean;
    logic               last;
  } voxel_result_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_valid = 1'b0;
  logic [CFG_W-1:0]    cfg_data = '0;
  logic                in_valid = 1'b0;
  logic [SAMPLE_W-1:0] in_sample = '0;
  logic                out_stall = 1'b0;

  wire                 cfg_ready;
  wire                 in_stall;
  wire                 out_valid;
  wire [LEVEL_W-1:0]   level;
  wire [COORD_W-1:0]   vox_x;
  wire [COORD_W-1:0]   vox_y;
  wire [COORD_W-1:0]   vox_z;
  wire [MEAN_W-1:0]    mean;
  wire                 last;

  logic [SAMPLE_W-1:0] pending_samples[$];
  voxel_result_t       expected_voxels[$];

  logic [CFG_W-1:0]    model_log2;
  int unsigned         model_x;
  int unsigned         model_y;
  int unsigned         model_z;
  longint unsigned     level_sums[int];

  int                  errors = 0;
  int                  cycle_count = 0;
  bit                  in_taken = 1'b0;
  int                  in_gap = 0;
  bit                  in_calm = 1'b0;
  int                  stall_left = 0;
  bit                  stall_calm = 1'b0;
  voxel_result_t       want;

  volume_mipmap_box_downsample_top DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .sample_i    (in_sample),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .level_o     (level),
    .vox_x_o     (vox_x),
    .vox_y_o     (vox_y),
    .vox_z_o     (vox_z),
    .mean_o      (mean),
    .last_o      (last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [SAMPLE_W-1:0] random_sample();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) begin
      return '0;
    end else if (r == 1) begin
      return '1;
    end
    return SAMPLE_W'($urandom());
  endfunction

  function automatic void add_sample(logic [SAMPLE_W-1:0] s);
    pending_samples.insert(pending_samples.size(), s);
  endfunction

  // Adds one sample to the running sums of every level and queues the cubes it completes.
  function automatic void accumulate_sample(logic [SAMPLE_W-1:0] s);
    int unsigned     eff;
    int unsigned     edge_len;
    int unsigned     lowm;
    int unsigned     res;
    int              key;
    int              first_n;
    bit              opens;
    bit              closes;
    longint unsigned sum;
    voxel_result_t   r;
    eff = model_log2;
    if (eff < 1) eff = 1;
    if (eff > 8) eff = 8;
    edge_len = 1 << eff;
    first_n = expected_voxels.size();
    for (int unsigned k = 1; k <= eff; k++) begin
      lowm = (1 << k) - 1;
      res = edge_len >> k;
      key = k * 65536 + (model_y >> k) * res + (model_x >> k);
      opens = ((model_x & lowm) == 0) && ((model_y & lowm) == 0) && ((model_z & lowm) == 0);
      closes = ((model_x & lowm) == lowm) && ((model_y & lowm) == lowm) &&
               ((model_z & lowm) == lowm);
      sum = opens ? longint'(s) : level_sums[key] + longint'(s);
      level_sums[key] = sum;
      if (closes) begin
        r.level = LEVEL_W'(k);
        r.vox_x = COORD_W'(model_x >> k);
        r.vox_y = COORD_W'(model_y >> k);
        r.vox_z = COORD_W'(model_z >> k);
        r.mean = MEAN_W'((sum + (64'd1 << (3 * k - 1))) >> (3 * k));
        r.last = 1'b0;
        expected_voxels.insert(expected_voxels.size(), r);
      end
    end
    if (expected_voxels.size() > first_n) begin
      expected_voxels[expected_voxels.size() - 1].last = 1'b1;
    end
    model_x++;
    if (model_x >= edge_len) begin
      model_x = 0;
      model_y++;
      if (model_y >= edge_len) begin
        model_y = 0;
        model_z++;
        if (model_z >= edge_len) model_z = 0;
      end
    end
  endfunction

  function automatic void check_field(string fname, logic [15:0] exp_v, logic [15:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, exp_v, got_v);
      errors++;
    end
  endfunction

  task automatic queue_random(int n);
    repeat (n) add_sample(random_sample());
  endtask

  task automatic wait_idle();
    while (pending_samples.size() != 0 || in_valid || expected_voxels.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_volume_log2(logic [CFG_W-1:0] v);
    wait_idle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    model_log2 = v;
    model_x = 0;
    model_y = 0;
    model_z = 0;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
    in_taken = rst_n && in_valid && !in_stall;
    if (in_taken) accumulate_sample(in_sample);
  end

  always @(negedge clk) begin
    if ($urandom_range(0, 63) == 0) in_calm = ~in_calm;
    if (rst_n && (!in_valid || in_taken)) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (pending_samples.size() != 0) begin
        in_valid <= 1'b1;
        in_sample <= pending_samples.pop_front();
        in_gap = in_calm ? 0 : pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if ($urandom_range(0, 63) == 0) stall_calm = ~stall_calm;
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      if (!stall_calm) stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_voxels.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual level %0d (%0d,%0d,%0d) mean %0d",
                 $time, level, vox_x, vox_y, vox_z, mean);
        errors++;
      end else begin
        want = expected_voxels.pop_front();
        check_field("level", want.level, level);
        check_field("vox_x", want.vox_x, vox_x);
        check_field("vox_y", want.vox_y, vox_y);
        check_field("vox_z", want.vox_z, vox_z);
        check_field("mean", want.mean, mean);
        check_field("last", want.last, last);
      end
    end
  end

  initial begin
    model_log2 = CFG_RESET;
    model_x = 0;
    model_y = 0;
    model_z = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    add_sample(16'h0000);
    add_sample(16'hFFFF);
    add_sample(16'h5555);
    add_sample(16'hAAAA);

    // A setting of zero behaves as an edge of two, so eight samples close one cube.
    write_volume_log2(4'd0);
    repeat (8) add_sample(16'hFFFF);
    repeat (7) add_sample(16'h0000);
    add_sample(16'h0004);

    write_volume_log2(4'd15);
    add_sample(16'h0001);
    add_sample(16'h8000);
    add_sample(16'h7FFF);
    add_sample(16'hFFFE);

    write_volume_log2(4'd2);
    queue_random(64);
    wait_idle();
    queue_random(64);

    // The writes of 1 and of 2 below land in the middle of a volume and restart it.
    write_volume_log2(4'd3);
    queue_random(70);
    write_volume_log2(4'd1);
    queue_random(80);
    write_volume_log2(4'd8);
    queue_random(20);
    write_volume_log2(4'd2);
    queue_random(50);

    wait_idle();
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
